>>> rtl/ppt_pkg.sv
// ----------------------------------------------------------------------------
// ppt_pkg: shared types and constants for the pure-pursuit turn-rate block
// Widths, register indexes, payload layouts and trig polynomial coefficients.
// ----------------------------------------------------------------------------
package ppt_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int ANGLE_BITS_DEF = 16;
    localparam int CFG_W          = 31;
    localparam int POS_W          = 32;
    localparam int HDG_W          = 16;
    localparam int RATE_W         = 32;
    localparam int CFG_IDX_W      = 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CRUISE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 1'd1;

    localparam logic [30:0] MASK31 = 31'h7FFF_FFFF;
    localparam logic [31:0] Q30_ONE = 32'h4000_0000;

    // Q30 Taylor coefficients
    localparam logic [31:0] SIN_K0 = 32'd1686629713;
    localparam logic [31:0] SIN_K1 = 32'd693598668;
    localparam logic [31:0] SIN_K2 = 32'd85569306;
    localparam logic [31:0] SIN_K3 = 32'd5026995;
    localparam logic [31:0] SIN_K4 = 32'd172272;
    localparam logic [31:0] SIN_K5 = 32'd3864;
    localparam logic [31:0] COS_K1 = 32'd1324675879;
    localparam logic [31:0] COS_K2 = 32'd272375560;
    localparam logic [31:0] COS_K3 = 32'd22401992;
    localparam logic [31:0] COS_K4 = 32'd987048;
    localparam logic [31:0] COS_K5 = 32'd27060;
    localparam logic [31:0] COS_K6 = 32'd506;

    // Request and result payloads
    typedef struct packed {
        logic signed [POS_W-1:0] robot_x;
        logic signed [POS_W-1:0] robot_y;
        logic [HDG_W-1:0]        robot_heading;
        logic signed [POS_W-1:0] target_x;
        logic signed [POS_W-1:0] target_y;
    } t_req;

    typedef struct packed {
        logic [CFG_W-1:0]         linear_speed;
        logic signed [RATE_W-1:0] turn_rate;
        logic                     rate_fault;
    } t_rsp;

    // Q30 multiply, rounded half up (operands below 2^31)
    function automatic logic [31:0] mulq30(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = {32'd0, a} * {32'd0, b} + 64'd536870912;
        return p[61:30];
    endfunction

endpackage

>>> rtl/ppt_if.sv
// ----------------------------------------------------------------------------
// ppt_if: valid/ready channel carrying a generic payload
// Source drives valid and data, sink drives ready.
// ----------------------------------------------------------------------------
interface ppt_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/pure_pursuit_turn_rate.sv
// Pipeline: 60 register stages from request acceptance to result valid;
// the accepting edge loads the first.
// Throughput: one request per cycle; a stalled result holds each full stage with
// no empty stage after it, and ready falls only when stage 0 is full and cannot move.
// Reset: synchronous, active low; clears valid bits and loads cruise_speed
// = 1.0 and rate_limit = 1000.0 (saturated to 31 bits).
// ----------------------------------------------------------------------------
// pure_pursuit_turn_rate: pure-pursuit curvature steering
// Rotates the target offset into the robot frame and gives w = 2*v*y0/r^2.
// ----------------------------------------------------------------------------
module pure_pursuit_turn_rate
    import ppt_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    ppt_if.sink                  s_req,
    ppt_if.source                m_rsp
);
    // Pipeline depth: 1 (angle) + 12 (trig Horner) + 1 (quadrant) + 2 (rotation)
    // + 1 (abs/prescale) + 1 (square sum) + 1 (numerator) + 40 (divider) + 1 (out)
    localparam int QW    = 34;                 // quotient bits kept (saturation)
    localparam int NSTG  = 60;

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    localparam logic [63:0] LIM_RAW = 64'd1000 << FRAC_BITS;
    localparam logic [30:0] LIM_RST = (LIM_RAW > 64'h7FFF_FFFF) ? MASK31 : LIM_RAW[30:0];
    localparam logic [30:0] SPD_RST = 31'(64'd1 << FRAC_BITS);

    logic [CFG_W-1:0] r_cruise, r_limit;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cruise <= SPD_RST;
            r_limit  <= LIM_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CRUISE: r_cruise <= i_cfg_data;
                REG_LIMIT:  r_limit  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Stage payload. One struct carries every field; each stage fills its part.
    // ------------------------------------------------------------------------
    typedef struct packed {
        logic signed [32:0]  dx;
        logic signed [32:0]  dy;
        logic [1:0]          quad;
        logic [31:0]         u;
        logic [31:0]         u2;
        logic [31:0]         sv;
        logic [31:0]         cv;
        logic signed [31:0]  c;
        logic signed [31:0]  s;
        logic signed [65:0]  pa;   // rotation partials
        logic signed [65:0]  pb;
        logic signed [65:0]  pc;
        logic signed [65:0]  pd;
        logic signed [35:0]  x0;
        logic signed [35:0]  y0;
        logic [30:0]         ax;
        logic [30:0]         ay;
        logic [1:0]          k;
        logic                neg;
        logic [62:0]         d;
        logic [96:0]         num;  // v*(|y0|>>k) << (F+1-k), quotient needs top bits
        logic [63:0]         rem;
        logic [QW-1:0]       q;
        logic [30:0]         spd;
    } t_st;

    t_st              r_st [NSTG];
    logic [NSTG-1:0]  r_vld;
    logic [NSTG-1:0]  w_adv;

    // Stage advance: a stage loads when it is empty or is being drained
    always_comb begin
        w_adv[NSTG-1] = !r_vld[NSTG-1] || m_rsp.ready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            w_adv[i] = !r_vld[i] || w_adv[i+1];
        end
    end
    assign s_req.ready = w_adv[0];

    // Divider: 97-bit numerator, one bit per step in the nominal scheme is too
    // slow, so each of the 40 stages retires up to BPS bits. We keep quotient to QW
    // bits with sticky saturation: numerator bits above are handled as the
    // first chunk. Bits per stage:
    localparam int NUM_W  = 97;
    localparam int DIV_ST = 40;
    localparam int BPS    = 3;     // 40*3 = 120 >= 97

    // ------------------------------------------------------------------------
    // Per-stage compute
    // ------------------------------------------------------------------------
    t_st n_st [NSTG];

    always_comb begin
        t_st a;
        logic [31:0] ang;
        logic signed [66:0] sx, sy;
        logic [35:0] tx, ty;
        logic [127:0] sh_num;
        logic [6:0]  sh;
        logic [64:0] rr;
        logic [QW:0] qq;
        logic [31:0] mag32;
        logic signed [32:0] wv;
        int bi;

        rr = '0;
        qq = '0;
        wv = '0;
        bi = 0;

        // stage 0: differences and angle (heading bits above ANGLE_BITS dropped)
        a = r_st[0];
        a.dx  = {s_req.data.target_x[31], s_req.data.target_x}
              - {s_req.data.robot_x[31], s_req.data.robot_x};
        a.dy  = {s_req.data.target_y[31], s_req.data.target_y}
              - {s_req.data.robot_y[31], s_req.data.robot_y};
        ang = (32'(s_req.data.robot_heading) & ((32'd1 << ANGLE_BITS) - 32'd1))
              << (32 - ANGLE_BITS);
        a.quad = ang[31:30];
        a.u    = {2'b00, ang[29:0]};
        a.spd  = r_cruise;
        n_st[0] = a;

        // stage 1: u^2
        a = r_st[0];
        a.u2 = mulq30(a.u, a.u);
        a.sv = SIN_K5;
        a.cv = COS_K6;
        n_st[1] = a;

        // stages 2..7: Horner steps, sin and cos in parallel
        a = r_st[1];
        a.sv = SIN_K4 - mulq30(a.u2, a.sv); a.cv = COS_K5 - mulq30(a.u2, a.cv);
        n_st[2] = a;
        a = r_st[2];
        a.sv = SIN_K3 - mulq30(a.u2, a.sv); a.cv = COS_K4 - mulq30(a.u2, a.cv);
        n_st[3] = a;
        a = r_st[3];
        a.sv = SIN_K2 - mulq30(a.u2, a.sv); a.cv = COS_K3 - mulq30(a.u2, a.cv);
        n_st[4] = a;
        a = r_st[4];
        a.sv = SIN_K1 - mulq30(a.u2, a.sv); a.cv = COS_K2 - mulq30(a.u2, a.cv);
        n_st[5] = a;
        a = r_st[5];
        a.sv = SIN_K0 - mulq30(a.u2, a.sv); a.cv = COS_K1 - mulq30(a.u2, a.cv);
        n_st[6] = a;
        a = r_st[6];
        a.sv = mulq30(a.u, a.sv);           a.cv = Q30_ONE - mulq30(a.u2, a.cv);
        n_st[7] = a;
        // stages 8..12: spare register slices for timing
        for (int i = 8; i <= 12; i++) n_st[i] = r_st[i-1];

        // stage 13: clamp and quadrant
        a = r_st[12];
        if (a.sv > Q30_ONE) a.sv = Q30_ONE;
        if (a.cv > Q30_ONE) a.cv = Q30_ONE;
        case (a.quad)
            2'd0: begin a.c = a.cv;  a.s = a.sv;  end
            2'd1: begin a.c = -a.sv; a.s = a.cv;  end
            2'd2: begin a.c = -a.cv; a.s = -a.sv; end
            default: begin a.c = a.sv; a.s = -a.cv; end
        endcase
        n_st[13] = a;

        // stage 14: four products, operands sign-extended to full width
        a = r_st[13];
        a.pa = 66'(a.c) * 66'(a.dx);
        a.pb = 66'(a.s) * 66'(a.dy);
        a.pc = 66'(a.c) * 66'(a.dy);
        a.pd = 66'(a.s) * 66'(a.dx);
        n_st[14] = a;

        // stage 15: sums and rounding shift
        a = r_st[14];
        sx = 67'(a.pa) + 67'(a.pb) + 67'sd536870912;
        sy = 67'(a.pc) - 67'(a.pd) + 67'sd536870912;
        a.x0 = 36'(sx >>> 30);
        a.y0 = 36'(sy >>> 30);
        n_st[15] = a;

        // stage 16: magnitudes and prescale
        a = r_st[15];
        tx = a.x0[35] ? 36'(-a.x0) : 36'(a.x0);
        ty = a.y0[35] ? 36'(-a.y0) : 36'(a.y0);
        a.neg = a.y0[35];
        if (tx[35:31] == '0 && ty[35:31] == '0)      a.k = 2'd0;
        else if (tx[35:32] == '0 && ty[35:32] == '0) a.k = 2'd1;
        else if (tx[35:33] == '0 && ty[35:33] == '0) a.k = 2'd2;
        else                                         a.k = 2'd3;
        a.ax = 31'(tx >> a.k);
        a.ay = 31'(ty >> a.k);
        n_st[16] = a;

        // stage 17: sum of squares
        a = r_st[16];
        a.d = 63'({32'd0, a.ax} * {32'd0, a.ax}) + 63'({32'd0, a.ay} * {32'd0, a.ay});
        n_st[17] = a;

        // stage 18: numerator v*ay (prescaled |y0|) shifted
        a = r_st[17];
        sh = 7'(FRAC_BITS + 1) - 7'(a.k);
        sh_num = 128'({33'd0, a.spd} * {33'd0, a.ay}) << sh;
        a.num = sh_num[96:0];
        a.rem = '0;
        a.q   = '0;
        n_st[18] = a;

        // stages 19..58: restoring division, up to BPS bits per stage
        for (int st = 0; st < DIV_ST; st++) begin
            a = r_st[18 + st];
            for (int b = 0; b < BPS; b++) begin
                bi = NUM_W - 1 - (st * BPS + b);
                if (bi >= 0) begin
                    rr = {a.rem, a.num[bi]};
                    if (rr >= {2'b00, a.d}) begin
                        rr = rr - {2'b00, a.d};
                        qq = {a.q, 1'b1};
                    end else begin
                        qq = {a.q, 1'b0};
                    end
                    a.rem = rr[63:0];
                    // sticky saturation at 2^(QW-1)
                    a.q = a.q[QW-1] ? a.q : qq[QW-1:0];
                end
            end
            n_st[19 + st] = a;
        end

        // stage 59: sign, saturation, limit and fault flag
        a = r_st[58];
        mag32 = 32'(a.q);
        if (a.d == 0) begin
            a.q = '0;
            a.neg = 1'b1;   // reuse as fault
            a.c = '0;
        end else begin
            if (!a.neg) begin
                wv = (a.q[QW-1:31] != 0) ? 33'sh7FFF_FFFF : $signed({1'b0, mag32});
            end else begin
                wv = (a.q[QW-1:31] != 0 && a.q != (QW'(1) << 31))
                     ? -33'sh8000_0000 : -$signed({1'b0, mag32});
            end
            if (wv > $signed({2'b00, r_limit})) begin
                a.c = '0;
                a.neg = 1'b1;
            end else begin
                a.c = wv[31:0];
                a.neg = 1'b0;
            end
        end
        n_st[59] = a;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) r_vld[0] <= s_req.valid;
            for (int i = 1; i < NSTG; i++) begin
                if (w_adv[i]) r_vld[i] <= r_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NSTG; i++) begin
            if (w_adv[i]) r_st[i] <= n_st[i];
        end
    end

    assign m_rsp.valid             = r_vld[NSTG-1];
    assign m_rsp.data.linear_speed = r_st[NSTG-1].spd;
    assign m_rsp.data.turn_rate    = r_st[NSTG-1].c;
    assign m_rsp.data.rate_fault   = r_st[NSTG-1].neg;

endmodule

>>> verif/ppt_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppt_tb_pkg: bench constants for the turn-rate bench
// Register values the predictor starts from after reset.
// ----------------------------------------------------------------------------
package ppt_tb_pkg;
    import ppt_pkg::*;

    localparam logic [CFG_W-1:0] CRUISE_RST = 31'd65536;
    localparam logic [CFG_W-1:0] LIMIT_RST  = 31'd65536000;
endpackage

>>> verif/ppt_steer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppt_steer_checker: steering command predictor and result comparator
// Tracks register writes, predicts speed, turn rate and fault per request, and
// compares each result with the oldest prediction.
// ----------------------------------------------------------------------------
module ppt_steer_checker
    import ppt_pkg::*;
    import ppt_tb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    ppt_if                       req_ch,
    ppt_if                       rsp_ch,
    output int                   o_fail_cnt,
    output int                   o_pending
);
    logic [CFG_W-1:0] speed_q;
    logic [CFG_W-1:0] limit_q;
    t_rsp             cmd_q[$];

    function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
        return (a * b + 64'd536870912) >> 30;
    endfunction

    // cosine and sine of the heading, Q30 signed
    function automatic void heading_trig(input logic [HDG_W-1:0] hdg,
                                         output longint c, output longint s);
        logic [31:0]     ang;
        longint unsigned u, u2, sv, cv;
        longint unsigned sk[6];
        longint unsigned ck[7];
        sk = '{SIN_K0, SIN_K1, SIN_K2, SIN_K3, SIN_K4, SIN_K5};
        ck = '{Q30_ONE, COS_K1, COS_K2, COS_K3, COS_K4, COS_K5, COS_K6};
        ang = {hdg, 16'd0};
        u   = ang[29:0];
        u2  = q30_mul(u, u);
        sv  = sk[5];
        cv  = ck[6];
        for (int i = 4; i >= 0; i--) sv = sk[i] - q30_mul(u2, sv);
        sv = q30_mul(u, sv);
        for (int i = 5; i >= 0; i--) cv = ck[i] - q30_mul(u2, cv);
        if (sv > Q30_ONE) sv = Q30_ONE;
        if (cv > Q30_ONE) cv = Q30_ONE;
        case (ang[31:30])
            2'd0: begin c = cv;  s = sv;  end
            2'd1: begin c = -sv; s = cv;  end
            2'd2: begin c = -cv; s = -sv; end
            default: begin c = sv; s = -cv; end
        endcase
    endfunction

    function automatic t_rsp steer_cmd(t_req r, logic [CFG_W-1:0] v,
                                       logic [CFG_W-1:0] lim);
        longint          c, s, dx, dy, x0, y0, w;
        longint unsigned ax, ay, d, p;
        logic [127:0]    quo;
        int              k;
        t_rsp            o;
        heading_trig(r.robot_heading, c, s);
        dx = longint'(r.target_x) - longint'(r.robot_x);
        dy = longint'(r.target_y) - longint'(r.robot_y);
        x0 = (c * dx + s * dy + (64'sd1 <<< 29)) >>> 30;
        y0 = (c * dy - s * dx + (64'sd1 <<< 29)) >>> 30;
        ax = x0 < 0 ? -x0 : x0;
        ay = y0 < 0 ? -y0 : y0;
        k  = 0;
        while (ax >= 64'h8000_0000 || ay >= 64'h8000_0000) begin
            ax = ax >> 1;
            ay = ay >> 1;
            k++;
        end
        d = ax * ax + ay * ay;
        o.linear_speed = v;
        o.rate_fault   = 1'b0;
        w = 0;
        if (d == 0) begin
            o.rate_fault = 1'b1;   // target on top of robot
        end else begin
            p   = longint'(v) * ay;
            quo = ({64'd0, p} << (FRAC_BITS_DEF + 1 - k)) / {64'd0, d};
            if (y0 >= 0) w = (quo > 128'h7FFF_FFFF) ? 64'sh7FFF_FFFF : longint'(quo);
            else w = (quo > 128'h8000_0000) ? -64'sh8000_0000 : -longint'(quo);
            // only a positive excess is limited
            if (w > longint'(lim)) begin
                w = 0;
                o.rate_fault = 1'b1;
            end
        end
        o.turn_rate = w[31:0];
        return o;
    endfunction

    always @(posedge i_clk) begin
        t_rsp exp_r;
        t_rsp act_r;
        if (!i_rst_n) begin
            speed_q    <= CRUISE_RST;
            limit_q    <= LIMIT_RST;
            o_fail_cnt <= 0;
            o_pending  <= 0;
            cmd_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_CRUISE) speed_q <= i_cfg_data;
                else if (i_cfg_idx == REG_LIMIT) limit_q <= i_cfg_data;
            end
            if (req_ch.valid && req_ch.ready)
                cmd_q = {cmd_q, steer_cmd(req_ch.data, speed_q, limit_q)};
            if (rsp_ch.valid && rsp_ch.ready) begin
                act_r = rsp_ch.data;
                if (cmd_q.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, act_r);
                    o_fail_cnt <= o_fail_cnt + 1;
                end else begin
                    exp_r = cmd_q.pop_front();
                    if (exp_r.linear_speed !== act_r.linear_speed ||
                        exp_r.turn_rate !== act_r.turn_rate ||
                        exp_r.rate_fault !== act_r.rate_fault) begin
                        $display("%0t: mismatch expected %p actual %p", $time, exp_r, act_r);
                        o_fail_cnt <= o_fail_cnt + 1;
                    end
                end
            end
            o_pending <= cmd_q.size();
        end
    end
endmodule

>>> verif/tb_pure_pursuit_turn_rate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pure_pursuit_turn_rate: regression bench for the turn-rate block
// Drives directed and random pose/target requests over several register
// settings and idle patterns; the checker scores every result.
// ----------------------------------------------------------------------------
module tb_pure_pursuit_turn_rate;
    import ppt_pkg::*;
    import ppt_tb_pkg::*;

    localparam int ITEMS_PER_PHASE = 225;
    localparam int CYCLE_LIMIT     = 3_000_000;
    localparam int DRAIN_CYCLES    = 80;     // settling wait once the checker has no result pending

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;
    int                   fail_cnt;
    int                   pending;
    int                   cycle_cnt;

    // idle pattern knobs, set between phases
    bit sender_idle;
    bit receiver_stall;
    int idle_pct;
    bit long_hold_req;
    bit long_hold_done;
    int hold_cnt;

    ppt_if #(.T(t_req)) req_ch ();
    ppt_if #(.T(t_rsp)) rsp_ch ();

    pure_pursuit_turn_rate i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .s_req      (req_ch.sink),
        .m_rsp      (rsp_ch.source)
    );

    ppt_steer_checker i_chk (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .req_ch     (req_ch),
        .rsp_ch     (rsp_ch),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // watchdog
    initial begin
        cycle_cnt = 0;
        forever begin
            @(posedge clk);
            cycle_cnt++;
            if (cycle_cnt >= CYCLE_LIMIT) begin
                $display("pure_pursuit_turn_rate regression: fail");
                $finish;
            end
        end
    end

    // result side: random stalls, plus one long hold so the pipe backs up
    initial begin
        rsp_ch.ready   = 1'b0;
        long_hold_done = 1'b0;
        hold_cnt       = 0;
        forever begin
            @(posedge clk);
            if (long_hold_req && !long_hold_done) begin
                long_hold_done = 1'b1;
                hold_cnt       = 400;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= receiver_stall ? ($urandom_range(0, 99) >= idle_pct) : 1'b1;
            end
        end
    end

    // offer one request, return once it has been taken
    task automatic send_req(t_req r);
        if (sender_idle && $urandom_range(0, 99) < idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < idle_pct) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        // inputs only move at posedge, so ready seen at negedge holds at the edge
        @(negedge clk);
        while (!req_ch.ready) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic pause_valid();
        req_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // quiesce before touching the registers
    task automatic write_regs(logic [CFG_W-1:0] speed, logic [CFG_W-1:0] lim);
        pause_valid();
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_CRUISE;
        cfg_data <= speed;
        @(posedge clk);
        cfg_idx  <= REG_LIMIT;
        cfg_data <= lim;
        @(posedge clk);
        cfg_we   <= 1'b0;
        @(posedge clk);
    endtask

    function automatic t_req mk_req(int rx, int ry, int hdg, int tx, int ty);
        t_req r;
        r.robot_x       = rx;
        r.robot_y       = ry;
        r.robot_heading = hdg[15:0];
        r.target_x      = tx;
        r.target_y      = ty;
        return r;
    endfunction

    // mostly a target near the robot at a random scale, some fully random, some coincident
    function automatic t_req rand_req();
        t_req r;
        int   sel;
        int   ox;
        int   oy;
        sel             = $urandom_range(0, 9);
        r.robot_x       = $urandom;
        r.robot_y       = $urandom;
        r.robot_heading = 16'($urandom);
        ox = $signed($urandom) >>> $urandom_range(0, 31);
        oy = $signed($urandom) >>> $urandom_range(0, 31);
        if (sel < 2) begin
            r.target_x = $urandom;
            r.target_y = $urandom;
        end else if (sel == 2) begin
            r.target_x = r.robot_x;     // coincident target
            r.target_y = r.robot_y;
        end else begin
            r.target_x = r.robot_x + ox;
            r.target_y = r.robot_y + oy;
        end
        return r;
    endfunction

    initial begin
        logic [CFG_W-1:0] spd[8];
        logic [CFG_W-1:0] lmt[8];
        bit               snd_mode[8];
        bit               rcv_mode[8];

        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = REG_CRUISE;
        cfg_data      = '0;
        req_ch.valid  = 1'b0;
        req_ch.data   = '0;
        sender_idle   = 1'b0;
        receiver_stall = 1'b0;
        idle_pct      = 86;
        long_hold_req = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset register values
        send_req(mk_req(0, 0, 0, 32'sh0001_0000, 0));
        send_req(mk_req(0, 0, 16'h4000, 0, 32'sh0001_0000));
        send_req(mk_req(0, 0, 16'h8000, 32'sh0001_0000, 32'sh0001_0000));
        send_req(mk_req(0, 0, 16'hC000, 32'sh0002_0000, -32'sh0001_0000));
        send_req(mk_req(0, 0, 16'hFFFF, 32'sh0003_0000, 32'sh0000_8000));
        send_req(mk_req(5, 7, 16'h1234, 5, 7));                     // coincident target
        send_req(mk_req(0, 0, 16'h2000, 1, 0));                     // rotated offset rounds to (1, -1)
        send_req(mk_req(0, 0, 0, 0, 1));                            // lateral only, over limit
        send_req(mk_req(0, 0, 0, 0, -1));                           // large negative, saturates
        send_req(mk_req(0, 0, 0, 32'sh0000_0100, 32'sh0000_0001));
        send_req(mk_req(32'sh8000_0000, 32'sh8000_0000, 16'h6000,
                        32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
        send_req(mk_req(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'hA000,
                        32'sh8000_0000, 32'sh8000_0000));
        send_req(mk_req(32'sh7FFF_FFFF, 32'sh8000_0000, 16'h0001,
                        32'sh8000_0000, 32'sh7FFF_FFFF));
        send_req(mk_req(-1, -1, 16'h7FFF, -1, -1));
        write_regs(31'h7FFF_FFFF, 31'h7FFF_FFFF);
        send_req(mk_req(0, 0, 0, 0, 1));                            // positive saturation
        send_req(mk_req(0, 0, 0, 0, -1));
        send_req(mk_req(0, 0, 0, 32'sh0001_0000, 32'sh0001_0000));
        write_regs(31'd0, 31'd0);
        send_req(mk_req(0, 0, 0, 32'sh0001_0000, 32'sh0001_0000));  // zero speed
        send_req(mk_req(0, 0, 0, 32'sh0001_0000, -32'sh0001_0000));
        send_req(mk_req(1, 1, 0, 1, 1));

        // phase table: register setting and idle pattern
        spd = '{31'd65536, 31'h7FFF_FFFF, 31'd0, 31'd131072,
                31'd32768, 31'h7FFF_FFFF, 31'd65536, 31'd300000};
        lmt = '{31'd65536000, 31'h7FFF_FFFF, 31'd0, 31'd655360,
                31'h7FFF_FFFF, 31'd1, 31'd65536000, 31'd6553600};
        snd_mode = '{0, 1, 0, 1, 0, 1, 0, 1};
        rcv_mode = '{0, 0, 1, 1, 0, 0, 1, 1};
        for (int p = 0; p < 8; p++) begin
            if (p == 3) write_regs(31'($urandom), 31'($urandom));
            else write_regs(spd[p], lmt[p]);
            sender_idle    = snd_mode[p];
            receiver_stall = rcv_mode[p];
            // both sides idle a quarter of the time, one side alone mostly idle
            idle_pct = (snd_mode[p] && rcv_mode[p]) ? 26 : 86;
            if (p == 4) long_hold_req = 1'b1;   // back-pressure fills the pipe
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (p == 6 && n == ITEMS_PER_PHASE / 2) begin
                    // sender pause until the pipe has drained
                    pause_valid();
                    while (pending != 0) @(posedge clk);
                end
                send_req(rand_req());
            end
        end

        pause_valid();
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_cnt == 0)
            $display("pure_pursuit_turn_rate regression: pass");
        else
            $display("pure_pursuit_turn_rate regression: fail");
        $finish;
    end
endmodule
